@@ design/pfb_pkg.sv @@
// ----------------------------------------------------------------------------
// pfb_pkg
// shared types for the planar framebuffer: action codes, controller commands
// and datapath status
// ----------------------------------------------------------------------------
`default_nettype none

package pfb_pkg;

  typedef enum logic [1:0] {
    ACT_PLOT = 2'd0,
    ACT_FILL = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } pfb_act_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture an accepted word
    logic setup;     // row base multiply, walk start
    logic clr;       // clearing pass write
    logic pt_wr;     // point write-back or colour capture
    logic fl_wr;     // fill write-back of one byte column
    logic col_step;  // next byte column
    logic row_step;  // next row of the rectangle
    logic res_load;  // load the result register
  } pfb_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic     clr_last;
    logic     off;
    logic     empty;
    pfb_act_e act;
    logic     col_last;
    logic     row_last;
  } pfb_status_t;

endpackage

`default_nettype wire

@@ design/pfb_dp.sv @@
// ----------------------------------------------------------------------------
// pfb_dp
// framebuffer datapath: plane store, address generation, pixel masks,
// read-modify-write merge and result register
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_dp #(
  parameter int SCREEN_W = 640,
  parameter int SCREEN_H = 480
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  pfb_pkg::pfb_cmd_t   cmd_i,
  output pfb_pkg::pfb_status_t status_o,
  input  wire [1:0]           action_i,
  input  wire [9:0]           pos_x_i,
  input  wire [8:0]           pos_y_i,
  input  wire [9:0]           rect_w_i,
  input  wire [8:0]           rect_h_i,
  input  wire [3:0]           colour_i,
  output logic [3:0]          pixel_colour_o,
  output logic                off_screen_o
);
  import pfb_pkg::*;

  localparam int RowBytes = (SCREEN_W + 7) / 8;
  localparam int Depth    = RowBytes * SCREEN_H;
  localparam int AddrW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [31:0]      mem [Depth];
  logic [31:0]      rdata_q;

  pfb_act_e         act_q;
  logic [9:0]       x_q;
  logic [8:0]       y_q;
  logic [3:0]       colour_q;
  logic [10:0]      ex_q;
  logic [9:0]       ey_q;
  logic             off_q;
  logic             empty_q;
  logic [9:0]       col_q;
  logic [8:0]       row_q;
  logic [AddrW-1:0] row_base_q;
  logic [AddrW-1:0] clr_addr_q;
  logic [3:0]       pix_q;
  logic [3:0]       pixel_colour_q;
  logic             off_screen_q;

  logic [10:0]      xw;
  logic [9:0]       yh;
  logic [AddrW-1:0] addr;
  logic [9:0]       lo;
  logic [10:0]      col8;
  logic [10:0]      hi;
  logic [3:0]       len;
  logic [7:0]       run;
  logic [7:0]       fl_mask;
  logic [7:0]       pt_mask;
  logic [7:0]       mask8;
  logic [31:0]      spread;
  logic [31:0]      cw;
  logic [31:0]      merged;
  logic [31:0]      wdata;
  logic             we;
  logic [3:0]       pix;

  // clipped rectangle end and edge tests on the incoming word
  assign xw = {1'b0, pos_x_i} + {1'b0, rect_w_i};
  assign yh = {1'b0, pos_y_i} + {1'b0, rect_h_i};

  // fill mask of the current byte column
  assign lo      = (col_q < x_q) ? x_q : col_q;
  assign col8    = {1'b0, col_q} + 11'd8;
  assign hi      = (col8 < ex_q) ? col8 : ex_q;
  assign len     = 4'(hi - {1'b0, lo});
  assign run     = 8'((9'd1 << len) - 9'd1);
  assign fl_mask = run << lo[2:0];
  assign pt_mask = 8'd1 << x_q[2:0];
  assign mask8   = (act_q == ACT_FILL) ? fl_mask : pt_mask;
  assign spread  = {4{mask8}};
  assign cw      = {{8{colour_q[3]}}, {8{colour_q[2]}}, {8{colour_q[1]}}, {8{colour_q[0]}}};
  assign merged  = (rdata_q & ~spread) | (cw & spread);

  assign addr  = cmd_i.clr ? clr_addr_q : AddrW'(row_base_q + AddrW'(col_q[9:3]));
  assign we    = cmd_i.clr | cmd_i.fl_wr | (cmd_i.pt_wr & (act_q == ACT_PLOT));
  assign wdata = cmd_i.clr ? 32'd0 : merged;

  always_comb begin
    for (int p = 0; p < 4; p++) begin
      pix[p] = rdata_q[8*p + int'(x_q[2:0])];
    end
  end

  // plane store, read data registered
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_q <= mem[addr];
  end

  // clearing pass address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
    end
  end

  // item registers and walk position
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= pfb_act_e'(action_i);
      x_q      <= pos_x_i;
      y_q      <= pos_y_i;
      colour_q <= colour_i;
      ex_q     <= (xw > 11'(SCREEN_W)) ? 11'(SCREEN_W) : xw;
      ey_q     <= (yh > 10'(SCREEN_H)) ? 10'(SCREEN_H) : yh;
      off_q    <= ({1'b0, pos_x_i} >= 11'(SCREEN_W)) || ({1'b0, pos_y_i} >= 10'(SCREEN_H));
      empty_q  <= (rect_w_i == '0) || (rect_h_i == '0);
      pix_q    <= '0;
    end
    if (cmd_i.setup) begin
      col_q      <= {x_q[9:3], 3'b000};
      row_q      <= y_q;
      row_base_q <= AddrW'(y_q * RowBytes);
    end
    if (cmd_i.col_step) begin
      col_q <= col_q + 10'd8;
    end
    if (cmd_i.row_step) begin
      col_q      <= {x_q[9:3], 3'b000};
      row_q      <= row_q + 9'd1;
      row_base_q <= row_base_q + AddrW'(RowBytes);
    end
    if (cmd_i.pt_wr && (act_q == ACT_READ)) begin
      pix_q <= pix;
    end
    if (cmd_i.res_load) begin
      pixel_colour_q <= pix_q;
      off_screen_q   <= off_q && (act_q != ACT_NONE);
      col_q          <= '0;
      row_q          <= '0;
    end
  end

  assign status_o.clr_last = (clr_addr_q == AddrW'(Depth - 1));
  assign status_o.off      = off_q;
  assign status_o.empty    = empty_q;
  assign status_o.act      = act_q;
  assign status_o.col_last = (col8 >= ex_q);
  assign status_o.row_last = (({1'b0, row_q} + 10'd1) >= ey_q);

  assign pixel_colour_o = pixel_colour_q;
  assign off_screen_o   = off_screen_q;

endmodule

`default_nettype wire

@@ design/pfb_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfb_ctrl
// framebuffer controller: clearing pass, handshakes and the walk sequence
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  input  pfb_pkg::pfb_status_t status_i,
  output pfb_pkg::pfb_cmd_t    cmd_o
);
  import pfb_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_PT_RD,
    S_PT_WR,
    S_FL_RD,
    S_FL_WR,
    S_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_CLEAR: cmd_o.clr   = 1'b1;
      S_IDLE:  cmd_o.load  = in_valid_i;
      S_SETUP: cmd_o.setup = 1'b1;
      S_PT_RD: ;
      S_PT_WR: cmd_o.pt_wr = 1'b1;
      S_FL_RD: ;
      S_FL_WR: begin
        cmd_o.fl_wr    = 1'b1;
        cmd_o.col_step = !status_i.col_last;
        cmd_o.row_step = status_i.col_last && !status_i.row_last;
      end
      S_DONE:  cmd_o.res_load = !out_valid_q || !out_stall_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (status_i.clr_last) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SETUP;
          end
        end
        S_SETUP: begin
          priority if (status_i.off || (status_i.act == ACT_NONE)) begin
            state_q <= S_DONE;
          end else if (status_i.act == ACT_FILL) begin
            state_q <= status_i.empty ? S_DONE : S_FL_RD;
          end else begin
            state_q <= S_PT_RD;
          end
        end
        S_PT_RD: state_q <= S_PT_WR;
        S_PT_WR: state_q <= S_DONE;
        S_FL_RD: state_q <= S_FL_WR;
        S_FL_WR: begin
          if (status_i.col_last && status_i.row_last) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_FL_RD;
          end
        end
        S_DONE: begin
          if (cmd_o.res_load) begin
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ design/planar_framebuffer_fill.sv @@
// ----------------------------------------------------------------------------
// planar_framebuffer_fill
// 16-colour framebuffer held as four bit planes, one 32-bit store word per
// group of eight pixels; plot, rectangle fill and pixel read-back
// ----------------------------------------------------------------------------
//
//   channel | handshake               | word
//   --------+-------------------------+---------------------------------------------
//   in      | in_valid_i / in_stall_o | action, pos_x, pos_y, rect_w, rect_h, colour
//   out     | out_valid_o/out_stall_i | pixel_colour, off_screen
//
// plot and read pass through setup (row base multiply), store read, write-back or
// colour capture and result load; off-screen, empty and unused words go from setup
// straight to the result load; fills take one read and one write per byte column
// over the clipped rows, each byte column on the single store port
// after reset a clearing pass zeroes one store word a cycle over all ceil(SCREEN_W/8)
// * SCREEN_H words (38400 at 640 x 480) with in_stall_o high; a new word is
// taken while a result waits, and a stalled output holds only the result load
// ----------------------------------------------------------------------------
`default_nettype none

module planar_framebuffer_fill #(
  parameter int SCREEN_W = 640,
  parameter int SCREEN_H = 480
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire  [1:0] action_i,
  input  wire  [9:0] pos_x_i,
  input  wire  [8:0] pos_y_i,
  input  wire  [9:0] rect_w_i,
  input  wire  [8:0] rect_h_i,
  input  wire  [3:0] colour_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic [3:0] pixel_colour_o,
  output logic       off_screen_o
);
  import pfb_pkg::*;

  pfb_cmd_t    cmd;
  pfb_status_t status;

  // sequencing: clearing pass, handshakes, walk over byte columns and rows
  pfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // plane store and everything that touches pixel data
  pfb_dp #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .action_i       (action_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .rect_w_i       (rect_w_i),
    .rect_h_i       (rect_h_i),
    .colour_i       (colour_i),
    .pixel_colour_o (pixel_colour_o),
    .off_screen_o   (off_screen_o)
  );

  // no word taken while the store is being cleared
  a_clr_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> in_stall_o)
    else $error("word accepted during clearing pass");

  // clearing writes never collide with pixel write-backs
  a_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.clr && (cmd.pt_wr || cmd.fl_wr)))
    else $error("clear and pixel write at once");

  // a result is never loaded over one still waiting
  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while stalled");

  // one word in flight: the cycle after acceptance the input stalls
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second word taken while busy");

endmodule

`default_nettype wire
